// ===== hw/rtl/stma_pkg.sv =====
`default_nettype none

package stma_pkg;

    localparam int CMD_W       = 2;
    localparam int ROW_W       = 16;
    localparam int COL_W       = 16;
    localparam int VAL_W       = 32;
    localparam int KEY_W       = ROW_W + COL_W;
    localparam int WORD_W      = KEY_W + VAL_W;
    localparam int TOTAL_W     = 7;
    localparam int LIST_DEPTH_DEF = 32;

    localparam logic [CMD_W-1:0] CMD_LOAD_A = 2'd0;
    localparam logic [CMD_W-1:0] CMD_LOAD_B = 2'd1;
    localparam logic [CMD_W-1:0] CMD_MERGE  = 2'd2;

    typedef logic [WORD_W-1:0] t_word;

    typedef struct packed {
        logic              emit;
        logic              take_a;
        logic              take_b;
        logic [ROW_W-1:0]  row;
        logic [COL_W-1:0]  col;
        logic [VAL_W-1:0]  value;
    } t_step;

endpackage

`default_nettype wire

// ===== hw/rtl/stma_req_if.sv =====
`default_nettype none

interface stma_req_if;
    logic                              valid;
    logic                              ready;
    logic [stma_pkg::CMD_W-1:0]        cmd;
    logic [stma_pkg::ROW_W-1:0]        row_index;
    logic [stma_pkg::COL_W-1:0]        col_index;
    logic signed [stma_pkg::VAL_W-1:0] elem_value;

    modport source (output valid, cmd, row_index, col_index, elem_value, input ready);
    modport sink   (input valid, cmd, row_index, col_index, elem_value, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/stma_rsp_if.sv =====
`default_nettype none

interface stma_rsp_if;
    logic                              valid;
    logic                              ready;
    logic [stma_pkg::ROW_W-1:0]        out_row;
    logic [stma_pkg::COL_W-1:0]        out_col;
    logic signed [stma_pkg::VAL_W-1:0] out_value;
    logic                              is_last;
    logic                              is_empty;
    logic [stma_pkg::TOTAL_W-1:0]      total_count;

    modport source (output valid, out_row, out_col, out_value, is_last, is_empty,
                    total_count, input ready);
    modport sink   (input valid, out_row, out_col, out_value, is_last, is_empty,
                    total_count, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/sparse_triple_matrix_add.sv =====
`default_nettype none

// Channel  Dir  Payload                                              Accept
// i_req    in   cmd, row_index, col_index, elem_value                valid & ready
// o_rsp    out  out_row, out_col, out_value, is_last, is_empty,      valid & ready
//               total_count
//
// A load writes its list while idle. A merge steps through the accept in
// idle, a prime state for the registered list RAM reads, one compare/add
// step in the shared merge unit per A entry, B entry or matched pair taken,
// an end step and a closing flush; a stalled result register holds an emitting step and the flush.
// i_rst_n clears the list counts, sequencer and result valid; list contents
// are not cleared. i_req.ready is high only while idle.

module sparse_triple_matrix_add #(
    parameter int LIST_DEPTH = stma_pkg::LIST_DEPTH_DEF
) (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    stma_req_if.sink   i_req,
    stma_rsp_if.source o_rsp
);

    localparam int AW = (LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1;
    localparam int CW = $clog2(LIST_DEPTH + 1);
    localparam int NW = $clog2(2 * LIST_DEPTH + 1);

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_PRIME = 2'd1;
    localparam logic [1:0] S_STEP  = 2'd2;
    localparam logic [1:0] S_FLUSH = 2'd3;

    logic [1:0]    r_state, n_state;
    logic [CW-1:0] r_cnt_a, n_cnt_a;
    logic [CW-1:0] r_cnt_b, n_cnt_b;
    logic [CW-1:0] r_ptr_a, n_ptr_a;
    logic [CW-1:0] r_ptr_b, n_ptr_b;
    logic [NW-1:0] r_num, n_num;
    logic          r_pend_valid, n_pend_valid;
    logic          r_out_valid, n_out_valid;

    logic [stma_pkg::ROW_W-1:0]   r_pend_row, n_pend_row;
    logic [stma_pkg::COL_W-1:0]   r_pend_col, n_pend_col;
    logic [stma_pkg::VAL_W-1:0]   r_pend_val, n_pend_val;
    logic [stma_pkg::ROW_W-1:0]   r_out_row, n_out_row;
    logic [stma_pkg::COL_W-1:0]   r_out_col, n_out_col;
    logic [stma_pkg::VAL_W-1:0]   r_out_val, n_out_val;
    logic                         r_out_last, n_out_last;
    logic                         r_out_empty, n_out_empty;
    logic [stma_pkg::TOTAL_W-1:0] r_out_total, n_out_total;

    logic            wr_a;
    logic            wr_b;
    stma_pkg::t_word wr_word;
    stma_pkg::t_word rd_a;
    stma_pkg::t_word rd_b;
    logic            a_live;
    logic            b_live;
    logic            out_free;
    stma_pkg::t_step step;

    assign wr_word  = {i_req.row_index, i_req.col_index, i_req.elem_value};
    assign a_live   = (r_ptr_a < r_cnt_a);
    assign b_live   = (r_ptr_b < r_cnt_b);
    assign out_free = !r_out_valid || o_rsp.ready;

    stma_ram #(.WIDTH(stma_pkg::WORD_W), .DEPTH(LIST_DEPTH)) u_ram_a (
        .i_clk     (i_clk),
        .i_wr_en   (wr_a),
        .i_wr_addr (r_cnt_a[AW-1:0]),
        .i_wr_data (wr_word),
        .i_rd_addr (n_ptr_a[AW-1:0]),
        .o_rd_data (rd_a)
    );

    stma_ram #(.WIDTH(stma_pkg::WORD_W), .DEPTH(LIST_DEPTH)) u_ram_b (
        .i_clk     (i_clk),
        .i_wr_en   (wr_b),
        .i_wr_addr (r_cnt_b[AW-1:0]),
        .i_wr_data (wr_word),
        .i_rd_addr (n_ptr_b[AW-1:0]),
        .o_rd_data (rd_b)
    );

    stma_merge_unit u_merge (
        .i_a_live (a_live),
        .i_b_live (b_live),
        .i_word_a (rd_a),
        .i_word_b (rd_b),
        .o_step   (step)
    );

    always_comb begin
        n_state      = r_state;
        n_cnt_a      = r_cnt_a;
        n_cnt_b      = r_cnt_b;
        n_ptr_a      = r_ptr_a;
        n_ptr_b      = r_ptr_b;
        n_num        = r_num;
        n_pend_valid = r_pend_valid;
        n_pend_row   = r_pend_row;
        n_pend_col   = r_pend_col;
        n_pend_val   = r_pend_val;
        n_out_valid  = r_out_valid && !o_rsp.ready;
        n_out_row    = r_out_row;
        n_out_col    = r_out_col;
        n_out_val    = r_out_val;
        n_out_last   = r_out_last;
        n_out_empty  = r_out_empty;
        n_out_total  = r_out_total;
        wr_a         = 1'b0;
        wr_b         = 1'b0;

        unique case (r_state)
            S_IDLE: begin
                if (i_req.valid) begin
                    unique case (i_req.cmd)
                        stma_pkg::CMD_LOAD_A: begin
                            if (r_cnt_a < CW'(LIST_DEPTH)) begin
                                wr_a    = 1'b1;
                                n_cnt_a = r_cnt_a + 1'b1;
                            end
                        end
                        stma_pkg::CMD_LOAD_B: begin
                            if (r_cnt_b < CW'(LIST_DEPTH)) begin
                                wr_b    = 1'b1;
                                n_cnt_b = r_cnt_b + 1'b1;
                            end
                        end
                        stma_pkg::CMD_MERGE: begin
                            n_state      = S_PRIME;
                            n_num        = '0;
                            n_pend_valid = 1'b0;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_PRIME: begin
                n_state = S_STEP;
            end
            S_STEP: begin
                if (!a_live && !b_live) begin
                    n_state = S_FLUSH;
                end else if (!(step.emit && r_pend_valid && !out_free)) begin
                    if (step.take_a) begin
                        n_ptr_a = r_ptr_a + 1'b1;
                    end
                    if (step.take_b) begin
                        n_ptr_b = r_ptr_b + 1'b1;
                    end
                    if (step.emit) begin
                        if (r_pend_valid) begin
                            n_out_valid = 1'b1;
                            n_out_row   = r_pend_row;
                            n_out_col   = r_pend_col;
                            n_out_val   = r_pend_val;
                            n_out_last  = 1'b0;
                            n_out_empty = 1'b0;
                            n_out_total = '0;
                        end
                        n_pend_valid = 1'b1;
                        n_pend_row   = step.row;
                        n_pend_col   = step.col;
                        n_pend_val   = step.value;
                        n_num        = r_num + 1'b1;
                    end
                end
            end
            S_FLUSH: begin
                if (out_free) begin
                    n_out_valid  = 1'b1;
                    n_out_last   = 1'b1;
                    if (r_pend_valid) begin
                        n_out_row   = r_pend_row;
                        n_out_col   = r_pend_col;
                        n_out_val   = r_pend_val;
                        n_out_empty = 1'b0;
                        n_out_total = stma_pkg::TOTAL_W'(r_num);
                    end else begin
                        n_out_row   = '0;
                        n_out_col   = '0;
                        n_out_val   = '0;
                        n_out_empty = 1'b1;
                        n_out_total = '0;
                    end
                    n_pend_valid = 1'b0;
                    n_cnt_a      = '0;
                    n_cnt_b      = '0;
                    n_ptr_a      = '0;
                    n_ptr_b      = '0;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_cnt_a      <= '0;
            r_cnt_b      <= '0;
            r_ptr_a      <= '0;
            r_ptr_b      <= '0;
            r_num        <= '0;
            r_pend_valid <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_cnt_a      <= n_cnt_a;
            r_cnt_b      <= n_cnt_b;
            r_ptr_a      <= n_ptr_a;
            r_ptr_b      <= n_ptr_b;
            r_num        <= n_num;
            r_pend_valid <= n_pend_valid;
            r_out_valid  <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_pend_row  <= n_pend_row;
        r_pend_col  <= n_pend_col;
        r_pend_val  <= n_pend_val;
        r_out_row   <= n_out_row;
        r_out_col   <= n_out_col;
        r_out_val   <= n_out_val;
        r_out_last  <= n_out_last;
        r_out_empty <= n_out_empty;
        r_out_total <= n_out_total;
    end

    assign i_req.ready       = (r_state == S_IDLE);
    assign o_rsp.valid       = r_out_valid;
    assign o_rsp.out_row     = r_out_row;
    assign o_rsp.out_col     = r_out_col;
    assign o_rsp.out_value   = r_out_val;
    assign o_rsp.is_last     = r_out_last;
    assign o_rsp.is_empty    = r_out_empty;
    assign o_rsp.total_count = r_out_total;

`ifndef NO_ASSERTIONS
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cnt_a <= CW'(LIST_DEPTH)) && (r_cnt_b <= CW'(LIST_DEPTH)))
        else $error("list count beyond depth");

    a_empty_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_empty) |-> (r_out_last && r_out_total == '0))
        else $error("empty result must be the last one with zero count");

    a_count_on_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !r_out_last) |-> (r_out_total == '0))
        else $error("count shown on a non-final result");

    a_idle_ptrs: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) |-> (r_ptr_a == '0 && r_ptr_b == '0 && !r_pend_valid))
        else $error("merge state left over while idle");
`endif

endmodule

`default_nettype wire

// ===== hw/rtl/stma_ram.sv =====
`default_nettype none

module stma_ram #(
    parameter int WIDTH = stma_pkg::WORD_W,
    parameter int DEPTH = stma_pkg::LIST_DEPTH_DEF
) (
    input  wire logic                                   i_clk,
    input  wire logic                                   i_wr_en,
    input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_wr_addr,
    input  wire logic [WIDTH-1:0]                       i_wr_data,
    input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_rd_addr,
    output logic      [WIDTH-1:0]                       o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        r_rd_data <= r_mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;

endmodule

`default_nettype wire

// ===== hw/rtl/stma_merge_unit.sv =====
`default_nettype none

module stma_merge_unit (
    input  wire logic                   i_a_live,
    input  wire logic                   i_b_live,
    input  wire stma_pkg::t_word        i_word_a,
    input  wire stma_pkg::t_word        i_word_b,
    output stma_pkg::t_step             o_step
);

    logic [stma_pkg::KEY_W-1:0] key_a;
    logic [stma_pkg::KEY_W-1:0] key_b;
    logic [stma_pkg::VAL_W-1:0] val_a;
    logic [stma_pkg::VAL_W-1:0] val_b;
    logic [stma_pkg::VAL_W-1:0] sum;

    assign key_a = i_word_a[stma_pkg::WORD_W-1 -: stma_pkg::KEY_W];
    assign key_b = i_word_b[stma_pkg::WORD_W-1 -: stma_pkg::KEY_W];
    assign val_a = i_word_a[stma_pkg::VAL_W-1:0];
    assign val_b = i_word_b[stma_pkg::VAL_W-1:0];
    assign sum   = val_a + val_b;

    always_comb begin
        o_step = '0;
        if (i_a_live && (!i_b_live || key_a < key_b)) begin
            o_step.emit   = 1'b1;
            o_step.take_a = 1'b1;
            {o_step.row, o_step.col, o_step.value} = i_word_a;
        end else if (i_b_live && (!i_a_live || key_a > key_b)) begin
            o_step.emit   = 1'b1;
            o_step.take_b = 1'b1;
            {o_step.row, o_step.col, o_step.value} = i_word_b;
        end else if (i_a_live && i_b_live) begin
            o_step.emit   = (sum != '0);
            o_step.take_a = 1'b1;
            o_step.take_b = 1'b1;
            {o_step.row, o_step.col} = key_a;
            o_step.value  = sum;
        end
    end

endmodule

`default_nettype wire
